### rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Capacity, derived widths, command and status codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CountW = 5;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_FIND   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic             load_item;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
    logic             wr_item;   // write the held item, else the last read word
    logic             load_out;
    status_e          out_status;
    logic [AddrW-1:0] out_pos;
    logic [CntW-1:0]  out_count;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic less;      // last read entry < held item (signed)
    logic equal;     // last read entry == held item
    logic out_busy;  // result register full and not being taken
  } dp_sts_t;

endpackage

### rtl/spq_datapath.sv
// ----------------------------------------------------------------------------
// spq_datapath: entry store, compare and result register
// Holds the sorted entries in a single-port-write memory with registered
// read, a copy of the head entry, the current item and the output word.
// ----------------------------------------------------------------------------
module spq_datapath
  import spq_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dp_cmd_t                 cmd_i,
  output dp_sts_t                 sts_o,
  input  logic signed [DataW-1:0] item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output status_e                 out_status_o,
  output logic [PosW-1:0]         out_pos_o,
  output logic signed [DataW-1:0] out_head_o,
  output logic [CountW-1:0]       out_count_o
);

  logic signed [DataW-1:0] mem [DEPTH];
  logic signed [DataW-1:0] item_q;
  logic signed [DataW-1:0] rd_data_q;
  logic signed [DataW-1:0] head_q;
  logic signed [DataW-1:0] wr_data;
  logic                    out_valid_q;
  status_e                 out_status_q;
  logic [PosW-1:0]         out_pos_q;
  logic signed [DataW-1:0] out_head_q;
  logic [CountW-1:0]       out_count_q;

  assign wr_data = cmd_i.wr_item ? item_q : rd_data_q;

  // memory: no reset, only entries below the fill count are ever read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[cmd_i.rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
    if (cmd_i.wr_en && (cmd_i.wr_addr == '0)) begin
      head_q <= wr_data;
    end
    if (cmd_i.load_out) begin
      out_status_q <= cmd_i.out_status;
      out_pos_q    <= PosW'(cmd_i.out_pos);
      out_count_q  <= CountW'(cmd_i.out_count);
      out_head_q   <= (cmd_i.out_count == '0) ? '0 : head_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.less     = rd_data_q < item_q;
  assign sts_o.equal    = rd_data_q == item_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_pos_o    = out_pos_q;
  assign out_head_o   = out_head_q;
  assign out_count_o  = out_count_q;

endmodule

### rtl/spq_ctrl.sv
// ----------------------------------------------------------------------------
// spq_ctrl: command sequencer of the sorted priority queue
// Scans the entries one at a time, then shifts the tail up (insert) or
// down (remove) one entry at a time, a read then a write; keeps the fill count.
// ----------------------------------------------------------------------------
module spq_ctrl
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] in_cmd_i,
  output dp_cmd_t    cmd_o,
  input  dp_sts_t    sts_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  cmd_e             op_q, op_d;
  status_e          status_q, status_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  sh_q, sh_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [CntW-1:0]  sh_m1;
  logic [CntW-1:0]  sh_p1;
  logic             accept;

  assign sh_m1  = sh_q - CntW'(1);
  assign sh_p1  = sh_q + CntW'(1);
  assign accept = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    status_d = status_q;
    idx_d    = idx_q;
    sh_d     = sh_q;
    count_d  = count_q;
    pos_d    = pos_q;

    cmd_o            = '0;
    cmd_o.out_status = status_q;
    cmd_o.out_pos    = pos_q;
    cmd_o.out_count  = count_q;
    cmd_o.load_item  = accept;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d     = cmd_e'(in_cmd_i);
          idx_d    = '0;
          pos_d    = '0;
          status_d = ST_NOT_FOUND;
          case (in_cmd_i)
            CMD_INSERT: begin
              if (count_q == CntW'(DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            CMD_REMOVE, CMD_FIND: state_d = S_SCAN_RD;
            default:              state_d = S_DONE;
          endcase
        end
      end

      S_SCAN_RD: begin
        if (idx_q == count_q) begin
          if (op_q == CMD_INSERT) begin
            // nothing greater or equal: append at the tail
            pos_d   = idx_q[AddrW-1:0];
            state_d = S_PUT;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = idx_q[AddrW-1:0];
          state_d       = S_SCAN_CHK;
        end
      end

      S_SCAN_CHK: begin
        if (op_q == CMD_INSERT) begin
          if (!sts_i.less) begin
            pos_d   = idx_q[AddrW-1:0];
            sh_d    = count_q;
            state_d = S_SH_RD;
          end else begin
            idx_d   = idx_q + CntW'(1);
            state_d = S_SCAN_RD;
          end
        end else if (sts_i.equal) begin
          pos_d    = idx_q[AddrW-1:0];
          status_d = ST_OK;
          sh_d     = idx_q;
          state_d  = (op_q == CMD_REMOVE) ? S_SH_RD : S_DONE;
        end else begin
          idx_d   = idx_q + CntW'(1);
          state_d = S_SCAN_RD;
        end
      end

      S_SH_RD: begin
        if (op_q == CMD_INSERT) begin
          if (sh_q > CntW'(pos_q)) begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = sh_m1[AddrW-1:0];
            state_d       = S_SH_WR;
          end else begin
            state_d = S_PUT;
          end
        end else begin
          if (sh_p1 < count_q) begin
            cmd_o.rd_en   = 1'b1;
            cmd_o.rd_addr = sh_p1[AddrW-1:0];
            state_d       = S_SH_WR;
          end else begin
            count_d = count_q - CntW'(1);
            state_d = S_DONE;
          end
        end
      end

      S_SH_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = sh_q[AddrW-1:0];
        sh_d          = (op_q == CMD_INSERT) ? sh_m1 : sh_p1;
        state_d       = S_SH_RD;
      end

      S_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = pos_q;
        cmd_o.wr_item = 1'b1;
        count_d       = count_q + CntW'(1);
        status_d      = ST_OK;
        state_d       = S_DONE;
      end

      S_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      op_q     <= CMD_INSERT;
      status_q <= ST_OK;
      idx_q    <= '0;
      sh_q     <= '0;
      count_q  <= '0;
      pos_q    <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      status_q <= status_d;
      idx_q    <= idx_d;
      sh_q     <= sh_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
    end
  end

endmodule

### rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded sorted list of signed 32-bit words
// Slave stream takes a command word (insert, remove first equal, find first
// equal) with its value; the master stream returns one result word per
// command: status, position, head value and fill count.
//
// Use:
//   - s_axis: tuser carries the command, tdata the value. tready is high
//     only while the sequencer is idle; one command is in work at a time.
//   - m_axis: one word per accepted command. A result register parts the
//     two sides, so the next command is taken while a result still waits.
//   - The scan and the shift each move one entry at a time through the
//     entry memory's single read port with registered read data; a
//     reject (queue full, unused code) goes straight to the result.
//   - Reset empties the queue (fill count zero); memory is not cleared.
//   - A stalled receiver holds the result word; the sequencer waits in its
//     final state until the result register is free.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // command word
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] item_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // result word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [3:0] position, [35:4] head_value,
                                      // [40:36] count, [47:41] zero
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  dp_cmd_t                 dp_cmd;
  dp_sts_t                 dp_sts;
  status_e                 out_status;
  logic [PosW-1:0]         out_pos;
  logic signed [DataW-1:0] out_head;
  logic [CountW-1:0]       out_count;

  spq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser),
    .cmd_o      (dp_cmd),
    .sts_i      (dp_sts)
  );

  spq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .item_i       (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_pos_o    (out_pos),
    .out_head_o   (out_head),
    .out_count_o  (out_count)
  );

  // pack the result word, lowest field first
  assign m_axis_tdata = {7'd0, out_count, out_head, out_pos};
  assign m_axis_tuser = out_status;

endmodule

### tb/spq_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spq_result_checker: result prediction and comparison for the priority queue
// Watches both stream channels. Every accepted command word is applied to a
// private sorted list to work out the result word it must produce; every
// accepted result word is compared field by field with the oldest of those.
// ----------------------------------------------------------------------------
module spq_result_checker
  import spq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] item_value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,   // [3:0] position, [35:4] head_value,
                                      // [40:36] count, [47:41] zero
  input  logic [1:0]  m_axis_tuser,   // [1:0] status
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned compared_o,
  output int unsigned full_seen_o,
  output int unsigned hit_seen_o
);

  typedef struct {
    status_e            status;
    logic [PosW-1:0]    position;
    logic [DataW-1:0]   head;
    logic [CountW-1:0]  count;
  } result_t;

  // private copy of the list, ascending, smallest at index 0
  logic [DataW-1:0] sorted_vals [DEPTH];
  int unsigned      n_held;
  result_t          awaited [$];

  function automatic result_t apply_command(input logic [1:0] op,
                                            input logic [DataW-1:0] val);
    result_t     res;
    int unsigned pos;
    int          j;
    bit          hit;
    res.status = ST_NOT_FOUND;
    pos = 0;
    hit = 1'b0;
    if (op == CMD_INSERT) begin
      if (n_held >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // goes in front of the first entry not below it (so ahead of duplicates)
        pos = n_held;
        for (j = 0; j < n_held; j++) begin
          if (!($signed(sorted_vals[j]) < $signed(val))) begin
            pos = j;
            break;
          end
        end
        for (j = n_held; j > pos; j--) sorted_vals[j] = sorted_vals[j-1];
        sorted_vals[pos] = val;
        n_held++;
        res.status = ST_OK;
      end
    end else if (op == CMD_REMOVE || op == CMD_FIND) begin
      for (j = 0; j < n_held; j++) begin
        if (sorted_vals[j] == val) begin
          pos = j;
          hit = 1'b1;
          break;
        end
      end
      if (hit) begin
        res.status = ST_OK;
        if (op == CMD_REMOVE) begin
          for (j = pos; j + 1 < n_held; j++) sorted_vals[j] = sorted_vals[j+1];
          n_held--;
        end
      end
    end
    // unused code falls through: list untouched, not found
    res.position = pos[PosW-1:0];
    res.head     = (n_held > 0) ? sorted_vals[0] : '0;
    res.count    = n_held[CountW-1:0];
    return res;
  endfunction

  task automatic flag(input string what, input logic [31:0] want,
                      input logic [31:0] got);
    fail_count_o++;
    if (fail_count_o <= 10)
      $display("%0t: %s wrong, expected %h, got %h", $time, what, want, got);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      n_held       = 0;
      awaited.delete();
      fail_count_o = 0;
      pending_o    = 0;
      compared_o   = 0;
      full_seen_o  = 0;
      hit_seen_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited.size() == 0) begin
          flag("result word with nothing awaited", '0, m_axis_tdata[31:0]);
        end else begin
          want = awaited.pop_front();
          compared_o++;
          if (m_axis_tuser !== want.status)
            flag("status", 32'(want.status), 32'(m_axis_tuser));
          if (m_axis_tdata[3:0] !== want.position)
            flag("position", 32'(want.position), 32'(m_axis_tdata[3:0]));
          if (m_axis_tdata[35:4] !== want.head)
            flag("head value", want.head, m_axis_tdata[35:4]);
          if (m_axis_tdata[40:36] !== want.count)
            flag("count", 32'(want.count), 32'(m_axis_tdata[40:36]));
          if (m_axis_tdata[47:41] !== 7'd0)
            flag("padding", '0, 32'(m_axis_tdata[47:41]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = apply_command(s_axis_tuser, s_axis_tdata);
        if (want.status == ST_FULL) full_seen_o++;
        if (want.status == ST_OK && s_axis_tuser != CMD_INSERT) hit_seen_o++;
        awaited.push_back(want);
      end
      pending_o = awaited.size();
    end
  end

endmodule

### tb/sorted_priority_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: stream-level test of the sorted priority queue
// A short directed run walks the extremes, duplicates, misses, the unused
// command code and a full queue; random traffic with shifting insert bias
// then fills and drains the list under three idling regimes. A checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam logic [1:0]  CmdUnused    = 2'd3;
  localparam logic [31:0] IntMin       = 32'h8000_0000;
  localparam logic [31:0] IntMax       = 32'h7FFF_FFFF;
  localparam int unsigned RandomWords  = 1722;
  localparam int unsigned SettleCycles = 2 * DEPTH + 12;
  localparam int unsigned PoolSize     = 6;
  localparam int unsigned LogSize      = 32;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int unsigned fail_count, pending, compared, full_seen, hit_seen;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned insert_pct    = 50;
  int unsigned block_left    = 0;
  int unsigned cmd_sent [4]  = '{0, 0, 0, 0};

  // small values reused often so that duplicates and hits are common
  logic [31:0] value_pool [PoolSize] = '{32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'h0,
                                         32'h1, 32'h2, 32'h5};
  // recently inserted values, source of remove and find targets
  logic [31:0] inserted_log [$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  sorted_priority_queue dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  spq_result_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .compared_o    (compared),
    .full_seen_o   (full_seen),
    .hit_seen_o    (hit_seen)
  );

  // receiver stalls at random
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one command word; gaps before it at the sender's idle rate
  task automatic send_word(input logic [1:0] op, input logic [31:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= val;
    do @(posedge clk_i); while (!s_axis_tready);
    cmd_sent[op]++;
    if (op == CMD_INSERT) begin
      inserted_log.push_back(val);
      if (inserted_log.size() > LogSize) void'(inserted_log.pop_front());
    end
  endtask

  // hold the sender off until every result word has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] fresh_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return value_pool[$urandom_range(PoolSize - 1)];
      4: begin
        case ($urandom_range(3))
          0:       return IntMin;
          1:       return IntMax;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic random_word();
    logic [1:0]  op;
    logic [31:0] val;
    // insert bias drifts per block of 40 words, so the list fills and drains
    if (block_left == 0) begin
      insert_pct = $urandom_range(15, 85);
      block_left = 40;
    end
    block_left--;
    if ($urandom_range(31) == 0)
      value_pool[$urandom_range(PoolSize - 1)] = $urandom_range(40) - 20;
    if ($urandom_range(99) < 3)                  op = CmdUnused;
    else if ($urandom_range(99) < insert_pct)    op = CMD_INSERT;
    else if ($urandom_range(1) == 1)             op = CMD_REMOVE;
    else                                         op = CMD_FIND;
    if (op == CMD_INSERT || inserted_log.size() == 0 || $urandom_range(9) < 3)
      val = fresh_value();
    else
      val = inserted_log[$urandom_range(inserted_log.size() - 1)];
    send_word(op, val);
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned k;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 17;
    recv_idle_pct = 61;

    // misses on an empty queue
    send_word(CMD_FIND,   32'd5);
    send_word(CMD_REMOVE, 32'd5);
    // extremes, duplicate goes ahead of its equal
    send_word(CMD_INSERT, 32'd0);
    send_word(CMD_INSERT, IntMax);
    send_word(CMD_INSERT, IntMin);
    send_word(CMD_INSERT, 32'd0);
    send_word(CMD_INSERT, 32'hFFFF_FFFF);
    send_word(CMD_FIND,   32'd0);
    send_word(CmdUnused,  32'hA5A5_5A5A);
    // head and tail removal, then a miss
    send_word(CMD_REMOVE, IntMin);
    send_word(CMD_REMOVE, IntMax);
    send_word(CMD_REMOVE, 32'd7);
    // three left: fill to capacity, then one insert too many
    for (k = 0; k < DEPTH - 3; k++) send_word(CMD_INSERT, $urandom());
    send_word(CMD_INSERT, 32'd0);
    send_word(CMD_REMOVE, 32'd0);
    send_word(CMD_FIND,   32'hFFFF_FFFF);
    wait_drained();

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 17; recv_idle_pct = 61; end
        1: begin send_idle_pct = 61; recv_idle_pct = 17; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (k = 0; k < RandomWords / 3; k++) begin
        random_word();
        if (k % 200 == 199) wait_drained();
      end
    end

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Covered %0d inserts, %0d removes, %0d finds, %0d unused codes.",
             cmd_sent[CMD_INSERT], cmd_sent[CMD_REMOVE], cmd_sent[CMD_FIND],
             cmd_sent[CmdUnused]);
    $display("%0d result words compared, %0d full rejections, %0d remove/find hits.",
             compared, full_seen, hit_seen);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Run stopped by the time limit, %0d result words outstanding.", pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
